/* src/gca_pkg.sv */
`default_nettype none
package gca_pkg;

  // Width of one clearance value and of each size register
  localparam int CLR_W = 9;
  localparam int CFG_W = 9;

  // Register index width and register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLUMNS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS    = 1'd1;

  // Size registers come out of reset at this value
  localparam int SIZE_RESET = 256;

  // Stream widths
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 16;

  // Shift command broadcast along the column line
  typedef struct packed {
    logic             en;
    logic [CLR_W-1:0] value;
  } cell_ctrl_t;

  // One result item
  typedef struct packed {
    logic [CLR_W-1:0] clearance;
    logic             is_obstacle;
    logic             map_done;
  } result_t;

endpackage
`default_nettype wire

/* src/gca_cell.sv */
`default_nettype none
module gca_cell (
  input  wire                         clk,
  input  wire gca_pkg::cell_ctrl_t    ctrl,
  input  wire                         load,
  input  wire [gca_pkg::CLR_W-1:0]    prev,
  output logic [gca_pkg::CLR_W-1:0]   q
);

  logic [gca_pkg::CLR_W-1:0] val_r;
  logic [gca_pkg::CLR_W-1:0] val_nxt;

  // Take the new clearance at the entry point, otherwise the neighbour's value
  always_comb begin
    val_nxt = load ? ctrl.value : prev;
  end

  // Advance on every accepted item
  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      val_r <= val_nxt;
    end
  end

  assign q = val_r;

endmodule
`default_nettype wire

/* src/gca_line.sv */
`default_nettype none
module gca_line #(
  parameter int MAX_ROWS = 256
) (
  input  wire                               clk,
  input  wire gca_pkg::cell_ctrl_t          ctrl,
  input  wire [$clog2(MAX_ROWS)-1:0]        rows_last,
  output logic [gca_pkg::CLR_W-1:0]         tail
);

  localparam int RW = $clog2(MAX_ROWS);

  logic [RW-1:0]             entry;
  logic [gca_pkg::CLR_W-1:0] q [MAX_ROWS];

  // Enter so that a value reaches the tail exactly one column later
  assign entry = RW'(MAX_ROWS - 1) - rows_last;

  // Row of cells; each hands its value to the next one per item
  for (genvar i = 0; i < MAX_ROWS; i++) begin : g_cell
    if (i == 0) begin : g_head
      gca_cell u_cell (
        .clk  (clk),
        .ctrl (ctrl),
        .load (entry == RW'(i)),
        .prev (ctrl.value),
        .q    (q[i])
      );
    end else begin : g_body
      gca_cell u_cell (
        .clk  (clk),
        .ctrl (ctrl),
        .load (entry == RW'(i)),
        .prev (q[i-1]),
        .q    (q[i])
      );
    end
  end

  assign tail = q[MAX_ROWS-1];

endmodule
`default_nettype wire

/* src/gca_skid.sv */
`default_nettype none
module gca_skid (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  wire gca_pkg::result_t  in_data,
  output logic                   out_valid,
  input  wire                    out_ready,
  output gca_pkg::result_t       out_data
);

  logic              out_valid_r;
  logic              skid_valid_r;
  gca_pkg::result_t  out_r;
  gca_pkg::result_t  skid_r;
  logic              in_fire;
  logic              out_free;

  assign in_ready = !skid_valid_r;
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // Control: refill the output stage, park an item in the skid while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r  <= skid_valid_r || in_fire;
      skid_valid_r <= 1'b0;
    end else if (in_fire) begin
      skid_valid_r <= 1'b1;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (out_free) begin
      out_r <= skid_valid_r ? skid_r : in_data;
    end else if (in_fire) begin
      skid_r <= in_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  // Skid only fills behind a held output item
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds an item while the output stage is empty");

  // A stalled output with a parked item keeps both
  a_skid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && !out_ready) |=> (skid_valid_r && out_valid_r))
    else $error("item lost while output stalled");
`endif

endmodule
`default_nettype wire

/* src/grid_clearance_annotator.sv */
`default_nettype none
// Grid clearance annotator. Takes one blocked flag per item, scanning the last column
// first and each column from the last row up, and returns one item per cell with the
// side of the largest free square whose top-left corner is that cell (0 and the
// obstacle flag in tuser for a blocked cell, tlast on row 0 of column 0). One item is
// accepted per clock while in_tready is high; its result is registered in the output
// stage. The rate is set by the column line, a row of MAX_ROWS cells that all shift
// once per accepted item and deliver the right-hand neighbour's clearance at the
// tail. A two-entry output stage keeps the input moving while one result waits. No
// clearing pass runs after reset. A write to grid_columns or grid_rows restarts the
// scan at the last row and column; write them only while idle. Sizes of 0 act as 1,
// sizes above the maximum as the maximum.
module grid_clearance_annotator #(
  parameter int MAX_ROWS    = 256,
  parameter int MAX_COLUMNS = 256
) (
  input  wire                                clk,
  input  wire                                rst_n,
  // in_tdata: [0] cell_blocked
  input  wire                                in_tvalid,
  output logic                               in_tready,
  input  wire [gca_pkg::IN_TDATA_W-1:0]      in_tdata,
  // out_tdata: [8:0] clearance
  output logic                               out_tvalid,
  input  wire                                out_tready,
  output logic [gca_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // out_tuser: [0] is_obstacle
  output logic                               out_tuser,
  output logic                               out_tlast,
  input  wire                                cfg_wr_en,
  input  wire [gca_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire [gca_pkg::CFG_W-1:0]           cfg_wdata
);

  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CW    = $clog2(MAX_COLUMNS);
  localparam int RCW_R = (RW + 1 > gca_pkg::CFG_W) ? RW + 1 : gca_pkg::CFG_W;
  localparam int RCW_C = (CW + 1 > gca_pkg::CFG_W) ? CW + 1 : gca_pkg::CFG_W;
  localparam int ROWS_RST =
    (MAX_ROWS < gca_pkg::SIZE_RESET) ? MAX_ROWS - 1 : gca_pkg::SIZE_RESET - 1;
  localparam int COLS_RST =
    (MAX_COLUMNS < gca_pkg::SIZE_RESET) ? MAX_COLUMNS - 1 : gca_pkg::SIZE_RESET - 1;
  localparam int CLR_W = gca_pkg::CLR_W;

  logic [RW-1:0]      rows_last_r, rows_last_nxt, rows_wr_last;
  logic [CW-1:0]      cols_last_r, cols_last_nxt, cols_wr_last;
  logic [RW-1:0]      row_pos_r, row_pos_nxt;
  logic [CW-1:0]      col_pos_r, col_pos_nxt;
  logic [CLR_W-1:0]   below_clr_r, below_clr_nxt;
  logic [CLR_W-1:0]   below_right_r, below_right_nxt;
  logic [RCW_R-1:0]   wr_ext_r;
  logic [RCW_C-1:0]   wr_ext_c;
  logic [CLR_W-1:0]   right;
  logic [CLR_W-1:0]   min_br;
  logic [CLR_W-1:0]   min_all;
  logic [CLR_W-1:0]   clr;
  logic               blocked;
  logic               at_edge;
  logic               in_fire;
  logic               res_ready;
  gca_pkg::cell_ctrl_t line_ctrl;
  gca_pkg::result_t    res;
  gca_pkg::result_t    out_res;

  // Clamp written sizes and keep them as last index
  assign wr_ext_r = RCW_R'(cfg_wdata);
  assign wr_ext_c = RCW_C'(cfg_wdata);

  always_comb begin
    if (wr_ext_r == '0) begin
      rows_wr_last = '0;
    end else if (wr_ext_r > RCW_R'(MAX_ROWS)) begin
      rows_wr_last = RW'(MAX_ROWS - 1);
    end else begin
      rows_wr_last = RW'(wr_ext_r - 1'b1);
    end
    if (wr_ext_c == '0) begin
      cols_wr_last = '0;
    end else if (wr_ext_c > RCW_C'(MAX_COLUMNS)) begin
      cols_wr_last = CW'(MAX_COLUMNS - 1);
    end else begin
      cols_wr_last = CW'(wr_ext_c - 1'b1);
    end
  end

  // Decode register writes
  always_comb begin
    rows_last_nxt = rows_last_r;
    cols_last_nxt = cols_last_r;
    unique case (cfg_index)
      gca_pkg::CFG_GRID_COLUMNS: cols_last_nxt = cols_wr_last;
      gca_pkg::CFG_GRID_ROWS:    rows_last_nxt = rows_wr_last;
    endcase
  end

  // Clearance of the current cell
  assign blocked  = in_tdata[0];
  assign in_fire  = in_tvalid && in_tready;
  assign at_edge  = (row_pos_r == rows_last_r) || (col_pos_r == cols_last_r);
  assign min_br   = (below_right_r < below_clr_r) ? below_right_r : below_clr_r;
  assign min_all  = (right < min_br) ? right : min_br;

  always_comb begin
    if (blocked) begin
      clr = '0;
    end else if (at_edge) begin
      clr = CLR_W'(1);
    end else begin
      clr = min_all + 1'b1;
    end
  end

  // Advance the scan position and neighbour registers
  always_comb begin
    row_pos_nxt     = row_pos_r;
    col_pos_nxt     = col_pos_r;
    below_clr_nxt   = below_clr_r;
    below_right_nxt = below_right_r;
    if (cfg_wr_en) begin
      row_pos_nxt     = rows_last_nxt;
      col_pos_nxt     = cols_last_nxt;
      below_clr_nxt   = '0;
      below_right_nxt = '0;
    end else if (in_fire) begin
      below_clr_nxt   = clr;
      below_right_nxt = right;
      if (row_pos_r == '0) begin
        row_pos_nxt = rows_last_r;
        col_pos_nxt = (col_pos_r == '0) ? cols_last_r : col_pos_r - 1'b1;
      end else begin
        row_pos_nxt = row_pos_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_last_r   <= RW'(ROWS_RST);
      cols_last_r   <= CW'(COLS_RST);
      row_pos_r     <= RW'(ROWS_RST);
      col_pos_r     <= CW'(COLS_RST);
      below_clr_r   <= '0;
      below_right_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        rows_last_r <= rows_last_nxt;
        cols_last_r <= cols_last_nxt;
      end
      row_pos_r     <= row_pos_nxt;
      col_pos_r     <= col_pos_nxt;
      below_clr_r   <= below_clr_nxt;
      below_right_r <= below_right_nxt;
    end
  end

  // Column line: previous column's clearances
  assign line_ctrl.en    = in_fire;
  assign line_ctrl.value = clr;

  gca_line #(
    .MAX_ROWS (MAX_ROWS)
  ) u_line (
    .clk       (clk),
    .ctrl      (line_ctrl),
    .rows_last (rows_last_r),
    .tail      (right)
  );

  // Result item and output stage
  assign res.clearance   = clr;
  assign res.is_obstacle = blocked;
  assign res.map_done    = (row_pos_r == '0) && (col_pos_r == '0);

  gca_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (res_ready),
    .in_data   (res),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_res)
  );

  assign in_tready = res_ready;
  assign out_tdata = gca_pkg::OUT_TDATA_W'(out_res.clearance);
  assign out_tuser = out_res.is_obstacle;
  assign out_tlast = out_res.map_done;

`ifndef SYNTHESIS
  // Row counts down within a column
  a_row_step: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !cfg_wr_en && row_pos_r != '0) |=>
      (row_pos_r == $past(row_pos_r - 1'b1)))
    else $error("row position did not step down");

  // Row 0 wraps to the last row
  a_row_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !cfg_wr_en && row_pos_r == '0) |=> (row_pos_r == rows_last_r))
    else $error("row position did not wrap");

  // A register write clears the neighbour registers
  a_cfg_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en |=> (below_clr_r == '0 && below_right_r == '0))
    else $error("neighbour registers not cleared on restart");

  // Positions never leave the sizes in use
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (row_pos_r <= rows_last_r) && (col_pos_r <= cols_last_r))
    else $error("scan position out of range");
`endif

endmodule
`default_nettype wire

/* tb/grid_clearance_annotator_test.sv */
module grid_clearance_annotator_test;
  import gca_pkg::*;

  localparam int GRID_MAX    = 256;
  localparam int STALL_LIMIT = 4000;
  localparam int RANDOM_CELLS = 1400;
  localparam int FREE_SIDE    = 24;

  // Tracks the scan position, the previous column of clearances and the results still owed
  class clearance_scoreboard;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic [CLR_W-1:0] clr_column [GRID_MAX];
    logic [CLR_W-1:0] below_clr;
    logic [CLR_W-1:0] diag_clr;
    int unsigned      scan_row;
    int unsigned      scan_col;
    result_t          owed_results [$];
    int               errors;
    int               results_checked;
    int               maps_completed;
    int unsigned      peak_clearance;

    function new();
      width_reg  = CFG_W'(SIZE_RESET);
      height_reg = CFG_W'(SIZE_RESET);
      foreach (clr_column[i]) clr_column[i] = '0;
      errors          = 0;
      results_checked = 0;
      maps_completed  = 0;
      peak_clearance  = 0;
      restart_scan();
    endfunction

    // A size of 0 acts as 1, anything above the maximum as the maximum
    function int unsigned size_in_use(logic [CFG_W-1:0] value);
      if (value == 0) return 1;
      if (value > GRID_MAX) return GRID_MAX;
      return 32'(value);
    endfunction

    function void restart_scan();
      scan_row  = size_in_use(height_reg) - 1;
      scan_col  = size_in_use(width_reg) - 1;
      below_clr = '0;
      diag_clr  = '0;
    endfunction

    function void write_size(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      if (idx == CFG_GRID_COLUMNS) begin
        width_reg = value;
      end else if (idx == CFG_GRID_ROWS) begin
        height_reg = value;
      end
      restart_scan();
    endfunction

    function int pending();
      return owed_results.size();
    endfunction

    // Work out the clearance of one accepted cell and advance the scan
    function void note_cell(logic blocked);
      int unsigned      rows;
      int unsigned      cols;
      logic [CLR_W-1:0] right_clr;
      logic [CLR_W-1:0] least;
      logic [CLR_W-1:0] clr;
      result_t          item;
      rows      = size_in_use(height_reg);
      cols      = size_in_use(width_reg);
      right_clr = clr_column[scan_row];
      if (blocked) begin
        clr = '0;
      end else if (scan_row == rows - 1 || scan_col == cols - 1) begin
        clr = CLR_W'(1);
      end else begin
        least = below_clr;
        if (right_clr < least) least = right_clr;
        if (diag_clr < least) least = diag_clr;
        clr = least + 1'b1;
      end
      item.clearance   = clr;
      item.is_obstacle = blocked;
      item.map_done    = (scan_row == 0 && scan_col == 0);
      owed_results.insert(owed_results.size(), item);
      diag_clr             = right_clr;
      clr_column[scan_row] = clr;
      below_clr            = clr;
      // Step up the column, then left to the next column, wrapping at the map's end
      if (scan_row == 0) begin
        scan_row = rows - 1;
        scan_col = (scan_col == 0) ? cols - 1 : scan_col - 1;
      end else begin
        scan_row = scan_row - 1;
      end
    endfunction

    task report_mismatch(string what);
      $display("ERROR: result item %0d: %s", results_checked, what);
      errors++;
    endtask

    // Compare one accepted result item with the oldest one owed
    task check_result(logic [OUT_TDATA_W-1:0] tdata, logic tuser, logic tlast);
      result_t want;
      if (owed_results.size() == 0) begin
        report_mismatch($sformatf("unexpected item, tdata %0h", tdata));
        return;
      end
      want = owed_results.pop_front();
      results_checked++;
      if (tdata !== OUT_TDATA_W'(want.clearance))
        report_mismatch($sformatf("clearance %0d, expected %0d", tdata, want.clearance));
      if (tuser !== want.is_obstacle)
        report_mismatch($sformatf("obstacle flag %b, expected %b", tuser, want.is_obstacle));
      if (tlast !== want.map_done)
        report_mismatch($sformatf("map end %b, expected %b", tlast, want.map_done));
      if (want.map_done) maps_completed++;
      if (32'(want.clearance) > peak_clearance) peak_clearance = 32'(want.clearance);
    endtask
  endclass

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   out_tlast;
  logic                   cfg_wr_en  = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [CFG_W-1:0]       cfg_wdata  = '0;

  clearance_scoreboard sb;
  logic cell_q [$];
  int   send_idle_pct = 15;
  int   recv_idle_pct = 15;
  int   hold_left     = 0;
  int   stall_count   = 0;
  int   input_stalls  = 0;
  int   size_writes   = 0;
  int   random_cells  = 0;

  grid_clearance_annotator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Offer queued cells; hold an item until it is taken, idle at random between items
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) sb.note_cell(in_tdata[0]);
      if (in_tvalid && !in_tready) input_stalls++;
      if (!in_tvalid || in_tready) begin
        if (cell_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tdata  <= IN_TDATA_W'(cell_q.pop_front());
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Take results; hold off for a requested stretch, otherwise stall at random
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser, out_tlast);
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Drop the run if nothing moves for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en || !rst_n)
      stall_count = 0;
    else
      stall_count++;
    if (stall_count >= STALL_LIMIT) begin
      $display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

  task wait_idle();
    do @(posedge clk);
    while (cell_q.size() > 0 || in_tvalid || sb.pending() > 0);
  endtask

  task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.write_size(idx, value);
    size_writes++;
  endtask

  task set_grid(logic [CFG_W-1:0] cols, logic [CFG_W-1:0] rows);
    if ($urandom_range(1)) begin
      write_reg(CFG_GRID_COLUMNS, cols);
      write_reg(CFG_GRID_ROWS, rows);
    end else begin
      write_reg(CFG_GRID_ROWS, rows);
      write_reg(CFG_GRID_COLUMNS, cols);
    end
  endtask

  task queue_cells(int count, int blocked_pct);
    for (int i = 0; i < count; i++)
      cell_q.insert(cell_q.size(), ($urandom_range(99) < blocked_pct));
  endtask

  initial begin
    int cols;
    int rows;
    int count;
    int density;
    int phase;
    sb = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Default 256 by 256 map: first cells of the last column
    cell_q = {1'b0, 1'b1, 1'b0, 1'b1};
    wait_idle();
    // Zero sizes act as a single cell, so every item ends a map
    set_grid(CFG_W'(0), CFG_W'(0));
    cell_q = {1'b0, 1'b1};
    wait_idle();
    // 3 by 3 with one blocked cell at the top of the middle column
    set_grid(CFG_W'(3), CFG_W'(3));
    cell_q = {1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0};
    wait_idle();
    set_grid(CFG_W'(2), CFG_W'(2));
    cell_q = {1'b0, 1'b0, 1'b0, 1'b0};
    wait_idle();

    // Tall map above the row limit; hold the output off so the input backs up
    set_grid(CFG_W'(2), CFG_W'($urandom_range(257, 511)));
    hold_left = 400;
    queue_cells(512, 20);
    random_cells += 512;
    wait_idle();
    // Wide single-row map above the column limit
    set_grid(CFG_W'($urandom_range(257, 511)), CFG_W'(1));
    queue_cells(256, 30);
    random_cells += 256;
    wait_idle();

    // Mostly whole small maps with random obstacles, some cut short
    phase = 0;
    while (random_cells < RANDOM_CELLS) begin
      send_idle_pct = (phase >= 10 && phase < 22) ? 0 : 15;
      recv_idle_pct = send_idle_pct;
      cols = $urandom_range(1, 8);
      rows = $urandom_range(1, 10);
      case ($urandom_range(9))
        0: write_reg(CFG_GRID_COLUMNS, CFG_W'(cols));
        1: write_reg(CFG_GRID_ROWS, CFG_W'(rows));
        2: if ($urandom_range(1)) set_grid(CFG_W'(0), CFG_W'(rows));
           else set_grid(CFG_W'(cols), CFG_W'(0));
        3: set_grid(CFG_W'($urandom_range(1, 16)), CFG_W'($urandom_range(1, 16)));
        default: set_grid(CFG_W'(cols), CFG_W'(rows));
      endcase
      cols = sb.size_in_use(sb.width_reg);
      rows = sb.size_in_use(sb.height_reg);
      case ($urandom_range(4))
        0: density = 0;
        1: density = 5;
        2: density = 20;
        3: density = 50;
        default: density = 80;
      endcase
      if ($urandom_range(3) == 0)
        count = $urandom_range(1, 2 * cols * rows);
      else
        count = $urandom_range(1, 3) * cols * rows;
      queue_cells(count, density);
      random_cells += count;
      wait_idle();
      phase++;
    end

    // One larger free map, streamed with no idling on either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_grid(CFG_W'(FREE_SIDE), CFG_W'(FREE_SIDE));
    queue_cells(FREE_SIDE * FREE_SIDE, 0);
    wait_idle();
    repeat (8) @(posedge clk);

    $display("Checked %0d result items across %0d complete maps after %0d size writes",
             sb.results_checked, sb.maps_completed, size_writes);
    $display("Largest clearance %0d; input held back for %0d cycles",
             sb.peak_clearance, input_stalls);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* sim.f */
src/gca_pkg.sv
src/gca_cell.sv
src/gca_line.sv
src/gca_skid.sv
src/grid_clearance_annotator.sv
tb/grid_clearance_annotator_test.sv
